>>> hdl/mlnp_pkg.sv
// Shared types, codes and defaults for the multi-list node pool manager.
package mlnp_pkg;

    localparam int DEF_NODES = 32;
    localparam int DEF_LISTS = 8;
    localparam int DATA_W    = 32;
    localparam int READ_CAP  = 32;

    localparam logic [2:0] F_CREATE = 3'd0;
    localparam logic [2:0] F_APPEND = 3'd1;
    localparam logic [2:0] F_INSHD  = 3'd2;
    localparam logic [2:0] F_INSPOS = 3'd3;
    localparam logic [2:0] F_REMOVE = 3'd4;
    localparam logic [2:0] F_READ   = 3'd5;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_NOFREE = 3'd1;
    localparam logic [2:0] ST_NOSLOT = 3'd2;
    localparam logic [2:0] ST_BADLST = 3'd3;
    localparam logic [2:0] ST_POS    = 3'd4;

    typedef struct packed {
        logic [2:0]               func;
        logic [2:0]               ln;
        logic signed [DATA_W-1:0] data;
        logic [5:0]               pos;
    } t_op;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] data;
        logic [2:0]               ln;
        logic [5:0]               free;
        logic                     last;
    } t_res;

endpackage

>>> hdl/mlnp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mlnp_ram import mlnp_pkg::*; #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

>>> hdl/mlnp_front.sv
// Front end: accepts items, drops unused func codes, queues them for the back end.
module mlnp_front import mlnp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_valid,
    output t_op  o_op,
    input  logic i_take
);
    t_op        r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_acc;
    logic       w_deq;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_mem[r_rd];
    // drop items whose func code means nothing
    assign w_acc   = i_push && !o_full && (i_op.func <= F_READ);
    assign w_deq   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mem[r_wr] <= i_op;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_acc) begin
                r_wr <= ~r_wr;
            end
            if (w_deq) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_acc} - {1'b0, w_deq};
        end
    end
endmodule

>>> hdl/mlnp_outq.sv
// Result queue between the back end and the result ports.
module mlnp_outq import mlnp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_res,
    output logic o_full,
    output logic o_empty,
    output t_res o_res,
    input  logic i_pop
);
    t_res       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_acc;
    logic       w_deq;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_mem[r_rd];
    assign w_acc   = i_push && !o_full;
    assign w_deq   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mem[r_wr] <= i_res;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_acc) begin
                r_wr <= ~r_wr;
            end
            if (w_deq) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_acc} - {1'b0, w_deq};
        end
    end
endmodule

>>> hdl/mlnp_back.sv
// Back end: sequencer that walks and edits the linked lists in the node pool.
module mlnp_back import mlnp_pkg::*; #(
    parameter int NODES = DEF_NODES,
    parameter int LISTS = DEF_LISTS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_op_valid,
    input  t_op  i_op,
    output logic o_op_take,
    output logic o_res_push,
    output t_res o_res,
    input  logic i_res_full
);
    localparam int NW  = $clog2(NODES + 1);
    localparam int AW  = $clog2(NODES);
    localparam int LW  = (LISTS > 1) ? $clog2(LISTS) : 1;
    localparam int CW  = $clog2(LISTS + 1);
    localparam int CAP = (NODES < READ_CAP) ? NODES : READ_CAP;
    localparam logic [NW-1:0] NIL = NW'(NODES);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_WALK    = 4'd1;
    localparam logic [3:0] S_TAKEREQ = 4'd2;
    localparam logic [3:0] S_TAKE    = 4'd3;
    localparam logic [3:0] S_PREDWR  = 4'd4;
    localparam logic [3:0] S_LINKPRD = 4'd5;
    localparam logic [3:0] S_REM     = 4'd6;
    localparam logic [3:0] S_RD      = 4'd7;
    localparam logic [3:0] S_EMIT    = 4'd8;

    logic [3:0]               r_state, n_state;
    logic [2:0]               r_func, n_func;
    logic [2:0]               r_ln, n_ln;
    logic signed [DATA_W-1:0] r_data, n_data;
    logic [5:0]               r_pos, n_pos;
    logic [NW-1:0]            r_p, n_p;
    logic [5:0]               r_i, n_i;
    logic [5:0]               r_k, n_k;
    logic                     r_at_head, n_at_head;
    logic [2:0]               r_status, n_status;
    logic signed [DATA_W-1:0] r_dout, n_dout;
    logic [2:0]               r_lout, n_lout;
    logic [NW-1:0]            r_node, n_node;
    logic [NW-1:0]            r_free_head, n_free_head;
    logic [NW-1:0]            r_free, n_free;
    logic [CW-1:0]            r_lists, n_lists;
    logic [NW-1:0]            r_head [LISTS];
    logic [NODES-1:0]         r_lvalid;
    logic [AW-1:0]            r_lraddr;
    logic                     r_lrvalid;

    logic                     w_lwe, w_lre, w_vwe, w_vre;
    logic [AW-1:0]            w_lwaddr, w_lraddr, w_vwaddr, w_vraddr;
    logic [NW-1:0]            w_lwdata, w_lq, w_link_rd;
    logic [DATA_W-1:0]        w_vq;
    logic                     w_hwe;
    logic [LW-1:0]            w_hwaddr;
    logic [NW-1:0]            w_hwdata;

    logic [3:0]               w_in_ln4, w_r_ln4;
    logic [LW-1:0]            w_in_lidx, w_r_lidx, w_lists_idx;
    logic [4:0]               w_lists5;
    logic [NW-1:0]            w_in_head, w_r_head;
    logic                     w_have_free, w_bad_list, w_fin;
    logic [7:0]               w_free8, w_lists8;

    mlnp_ram #(.WIDTH(NW), .DEPTH(NODES)) u_link (
        .i_clk  (i_clk),
        .i_we   (w_lwe),
        .i_waddr(w_lwaddr),
        .i_wdata(w_lwdata),
        .i_re   (w_lre),
        .i_raddr(w_lraddr),
        .o_rdata(w_lq)
    );

    mlnp_ram #(.WIDTH(DATA_W), .DEPTH(NODES)) u_value (
        .i_clk  (i_clk),
        .i_we   (w_vwe),
        .i_waddr(w_vwaddr),
        .i_wdata(r_data),
        .i_re   (w_vre),
        .i_raddr(w_vraddr),
        .o_rdata(w_vq)
    );

    // a link never written still holds its reset chain value
    assign w_link_rd = r_lrvalid ? w_lq : (NW'(r_lraddr) + NW'(1));

    assign w_in_ln4    = {1'b0, i_op.ln};
    assign w_r_ln4     = {1'b0, r_ln};
    assign w_in_lidx   = w_in_ln4[LW-1:0];
    assign w_r_lidx    = w_r_ln4[LW-1:0];
    assign w_lists5    = 5'(r_lists);
    assign w_lists_idx = w_lists5[LW-1:0];
    assign w_in_head   = r_head[w_in_lidx];
    assign w_r_head    = r_head[w_r_lidx];
    assign w_have_free = (r_free != '0) && (r_free_head < NIL);
    assign w_bad_list  = ({2'b0, i_op.ln} >= w_lists5) || ({2'b0, i_op.ln} >= 5'(LISTS));
    assign w_fin       = (w_link_rd >= NIL) || ((r_k + 6'd1) >= 6'(CAP));
    assign w_free8     = 8'(r_free);
    assign w_lists8    = 8'(r_lists);

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_ln        = r_ln;
        n_data      = r_data;
        n_pos       = r_pos;
        n_p         = r_p;
        n_i         = r_i;
        n_k         = r_k;
        n_at_head   = r_at_head;
        n_status    = r_status;
        n_dout      = r_dout;
        n_lout      = r_lout;
        n_node      = r_node;
        n_free_head = r_free_head;
        n_free      = r_free;
        n_lists     = r_lists;
        w_lwe       = 1'b0;
        w_lwaddr    = '0;
        w_lwdata    = '0;
        w_lre       = 1'b0;
        w_lraddr    = '0;
        w_vwe       = 1'b0;
        w_vwaddr    = '0;
        w_vre       = 1'b0;
        w_vraddr    = '0;
        w_hwe       = 1'b0;
        w_hwaddr    = '0;
        w_hwdata    = '0;
        o_op_take   = 1'b0;
        o_res_push  = 1'b0;
        o_res       = '{status: r_status, data: r_dout, ln: r_lout,
                        free: w_free8[5:0], last: 1'b1};

        unique case (r_state)
            S_IDLE: begin
                if (i_op_valid) begin
                    o_op_take = 1'b1;
                    n_func    = i_op.func;
                    n_ln      = i_op.ln;
                    n_data    = i_op.data;
                    n_pos     = i_op.pos;
                    n_lout    = i_op.ln;
                    n_dout    = '0;
                    n_status  = ST_OK;
                    n_at_head = 1'b0;
                    n_k       = '0;
                    n_state   = S_EMIT;
                    if (i_op.func == F_CREATE) begin
                        if (r_lists >= CW'(LISTS)) begin
                            n_status = ST_NOSLOT;
                        end else if (!w_have_free) begin
                            n_status = ST_NOFREE;
                        end else begin
                            n_state = S_TAKEREQ;
                        end
                    end else if (w_bad_list) begin
                        n_status = ST_BADLST;
                    end else if (i_op.func == F_REMOVE || i_op.func == F_READ) begin
                        if (w_in_head >= NIL) begin
                            n_status = ST_POS;
                        end else begin
                            w_lre    = 1'b1;
                            w_lraddr = w_in_head[AW-1:0];
                            w_vre    = 1'b1;
                            w_vraddr = w_in_head[AW-1:0];
                            n_p      = w_in_head;
                            n_state  = (i_op.func == F_REMOVE) ? S_REM : S_RD;
                        end
                    end else if (!w_have_free) begin
                        n_status = ST_NOFREE;
                    end else if (i_op.func == F_INSHD) begin
                        n_at_head = 1'b1;
                        n_state   = S_TAKEREQ;
                    end else if (i_op.func == F_APPEND) begin
                        if (w_in_head >= NIL) begin
                            n_at_head = 1'b1;
                            n_state   = S_TAKEREQ;
                        end else begin
                            w_lre    = 1'b1;
                            w_lraddr = w_in_head[AW-1:0];
                            n_p      = w_in_head;
                            n_state  = S_WALK;
                        end
                    end else begin
                        if (i_op.pos == 6'd0) begin
                            n_status = ST_POS;
                        end else if (i_op.pos == 6'd1) begin
                            n_at_head = 1'b1;
                            n_state   = S_TAKEREQ;
                        end else if (w_in_head >= NIL) begin
                            n_status = ST_POS;
                        end else if (i_op.pos == 6'd2) begin
                            n_p     = w_in_head;
                            n_state = S_TAKEREQ;
                        end else begin
                            w_lre    = 1'b1;
                            w_lraddr = w_in_head[AW-1:0];
                            n_p      = w_in_head;
                            n_i      = 6'd1;
                            n_state  = S_WALK;
                        end
                    end
                end
            end
            S_WALK: begin
                if (r_func == F_APPEND) begin
                    if (w_link_rd >= NIL) begin
                        n_state = S_TAKEREQ;
                    end else begin
                        w_lre    = 1'b1;
                        w_lraddr = w_link_rd[AW-1:0];
                        n_p      = w_link_rd;
                    end
                end else begin
                    if (w_link_rd >= NIL) begin
                        n_status = ST_POS;
                        n_state  = S_EMIT;
                    end else begin
                        n_p = w_link_rd;
                        n_i = r_i + 6'd1;
                        if ((r_i + 6'd1) == (r_pos - 6'd1)) begin
                            n_state = S_TAKEREQ;
                        end else begin
                            w_lre    = 1'b1;
                            w_lraddr = w_link_rd[AW-1:0];
                        end
                    end
                end
            end
            S_TAKEREQ: begin
                w_lre    = 1'b1;
                w_lraddr = r_free_head[AW-1:0];
                n_state  = S_TAKE;
            end
            S_TAKE: begin
                n_node      = r_free_head;
                n_free_head = w_link_rd;
                n_free      = r_free - NW'(1);
                w_vwe       = 1'b1;
                w_vwaddr    = r_free_head[AW-1:0];
                n_state     = S_EMIT;
                if (r_func == F_CREATE) begin
                    w_lwe    = 1'b1;
                    w_lwaddr = r_free_head[AW-1:0];
                    w_lwdata = NIL;
                    w_hwe    = 1'b1;
                    w_hwaddr = w_lists_idx;
                    w_hwdata = r_free_head;
                    n_lout   = w_lists8[2:0];
                    n_lists  = r_lists + CW'(1);
                end else if (r_at_head) begin
                    w_lwe    = 1'b1;
                    w_lwaddr = r_free_head[AW-1:0];
                    w_lwdata = w_r_head;
                    w_hwe    = 1'b1;
                    w_hwaddr = w_r_lidx;
                    w_hwdata = r_free_head;
                end else begin
                    w_lre    = 1'b1;
                    w_lraddr = r_p[AW-1:0];
                    n_state  = S_PREDWR;
                end
            end
            S_PREDWR: begin
                w_lwe    = 1'b1;
                w_lwaddr = r_node[AW-1:0];
                w_lwdata = w_link_rd;
                n_state  = S_LINKPRD;
            end
            S_LINKPRD: begin
                w_lwe    = 1'b1;
                w_lwaddr = r_p[AW-1:0];
                w_lwdata = r_node;
                n_state  = S_EMIT;
            end
            S_REM: begin
                // unlink the head and push it onto the free list
                w_hwe       = 1'b1;
                w_hwaddr    = w_r_lidx;
                w_hwdata    = w_link_rd;
                w_lwe       = 1'b1;
                w_lwaddr    = r_p[AW-1:0];
                w_lwdata    = r_free_head;
                n_free_head = r_p;
                n_free      = r_free + NW'(1);
                n_dout      = w_vq;
                n_state     = S_EMIT;
            end
            S_RD: begin
                o_res = '{status: ST_OK, data: w_vq, ln: r_ln,
                          free: w_free8[5:0], last: w_fin};
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_k        = r_k + 6'd1;
                    if (w_fin) begin
                        n_state = S_IDLE;
                    end else begin
                        w_lre    = 1'b1;
                        w_lraddr = w_link_rd[AW-1:0];
                        w_vre    = 1'b1;
                        w_vraddr = w_link_rd[AW-1:0];
                    end
                end
            end
            S_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_ln     <= n_ln;
        r_data   <= n_data;
        r_pos    <= n_pos;
        r_p      <= n_p;
        r_i      <= n_i;
        r_k      <= n_k;
        r_at_head <= n_at_head;
        r_status <= n_status;
        r_dout   <= n_dout;
        r_lout   <= n_lout;
        r_node   <= n_node;
        if (w_lre) begin
            r_lraddr  <= w_lraddr;
            r_lrvalid <= r_lvalid[w_lraddr];
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_free      <= NW'(NODES);
            r_lists     <= '0;
            r_lvalid    <= '0;
            for (int j = 0; j < LISTS; j++) begin
                r_head[j] <= NIL;
            end
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_free      <= n_free;
            r_lists     <= n_lists;
            if (w_lwe) begin
                r_lvalid[w_lwaddr] <= 1'b1;
            end
            if (w_hwe) begin
                r_head[w_hwaddr] <= w_hwdata;
            end
        end
    end
endmodule

>>> hdl/multi_list_node_pool_manager_top.sv
// Append walks the list to its tail and positional insert walks to the node before the position;
// one link is walked per cycle. A list read gives its elements in order, one per cycle while
// the result queue is not full, up to 32 (or NODES if that is fewer).
// Items are worked one at a time by the back-end sequencer; a 2-deep queue sits on each side.
// Synchronous active-low reset: all lists empty, free list chained 0..NODES-1, queues empty.
module multi_list_node_pool_manager_top import mlnp_pkg::*; #(
    parameter int NODES = DEF_NODES,
    parameter int LISTS = DEF_LISTS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [2:0]               i_func,
    input  logic [2:0]               i_list_number,
    input  logic signed [DATA_W-1:0] i_data_value,
    input  logic [5:0]               i_position,
    output logic                     empty,
    input  logic                     pop,
    output logic [2:0]               o_status,
    output logic signed [DATA_W-1:0] o_data_value_out,
    output logic [2:0]               o_list_number_out,
    output logic [5:0]               o_free_count,
    output logic                     o_last
);
    t_op  w_in_op, w_q_op;
    t_res w_res, w_out;
    logic w_q_valid, w_take, w_res_push, w_res_full;

    assign w_in_op = '{func: i_func, ln: i_list_number, data: i_data_value, pos: i_position};

    mlnp_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_op   (w_in_op),
        .o_full (full),
        .o_valid(w_q_valid),
        .o_op   (w_q_op),
        .i_take (w_take)
    );

    mlnp_back #(.NODES(NODES), .LISTS(LISTS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op_valid(w_q_valid),
        .i_op      (w_q_op),
        .o_op_take (w_take),
        .o_res_push(w_res_push),
        .o_res     (w_res),
        .i_res_full(w_res_full)
    );

    mlnp_outq u_outq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .i_res  (w_res),
        .o_full (w_res_full),
        .o_empty(empty),
        .o_res  (w_out),
        .i_pop  (pop)
    );

    assign o_status          = w_out.status;
    assign o_data_value_out  = w_out.data;
    assign o_list_number_out = w_out.ln;
    assign o_free_count      = w_out.free;
    assign o_last            = w_out.last;

`ifndef SYNTHESIS
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status <= ST_POS))
        else $error("result status out of range");
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_OK) |-> o_last)
        else $error("error result not marked last");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_OK) |-> (o_data_value_out == '0))
        else $error("error result carries data");
`endif
endmodule
